@@ rtl/mbp_pkg.sv @@
// shared types and constants for the msb-first bit packer
package mbp_pkg;

  localparam int unsigned NumSlots = 3;
  localparam int unsigned SlotW = 2;

  localparam logic [7:0] ByteMask = 8'hFF;
  localparam logic [3:0] QSizeReset = 4'd8;
  localparam logic [3:0] QSizeMax = 4'd8;
  localparam logic [3:0] QSizeMin = 4'd1;

  localparam logic [SlotW-1:0] SlotHeader = 2'd0;
  localparam logic [SlotW-1:0] SlotData = 2'd1;
  localparam logic [SlotW-1:0] SlotFlush = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } slot_t;

  typedef struct packed {
    slot_t [NumSlots-1:0] slots;
  } rec_t;

endpackage

@@ rtl/mbp_front.sv @@
// front end: width register, bit accumulator and per-item byte record
module mbp_front import mbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i,
  input  logic       accept_i,
  input  logic [7:0] field_value_i,
  input  logic       is_last_i,
  output logic       rec_push_o,
  output rec_t       rec_o
);

  logic [3:0]  q_size_q, q_size_d;
  logic [6:0]  acc_q, acc_d;
  logic [2:0]  held_q, held_d;
  logic        hdr_q, hdr_d;

  logic [3:0]  w;
  logic [7:0]  wmask;
  logic [7:0]  v;
  logic [14:0] cat;
  logic [3:0]  n;
  logic [3:0]  nn;
  logic        has_full;
  logic [14:0] remw;
  logic [6:0]  rem;
  logic [7:0]  data_byte;
  logic [7:0]  flush_byte;
  rec_t        rec;

  always_comb begin
    if (q_size_q == 4'd0) begin
      w = QSizeMin;
    end else if (q_size_q > QSizeMax) begin
      w = QSizeMax;
    end else begin
      w = q_size_q;
    end
    wmask = 8'((9'h1 << w) - 9'h1);
    v = field_value_i & ByteMask & wmask;
    cat = ({8'b0, acc_q} << w) | {7'b0, v};
    n = {1'b0, held_q} + w;
    has_full = (n >= 4'd8);
    nn = has_full ? (n - 4'd8) : n;
    data_byte = 8'(cat >> nn);
    remw = cat & ((15'h1 << nn) - 15'h1);
    rem = remw[6:0];
    flush_byte = 8'({1'b0, rem} << (4'd8 - nn));

    rec = '0;
    rec.slots[SlotHeader].valid = !hdr_q;
    rec.slots[SlotHeader].data = {4'b0, w};
    rec.slots[SlotHeader].last = 1'b0;
    rec.slots[SlotData].valid = has_full;
    rec.slots[SlotData].data = data_byte;
    rec.slots[SlotData].last = is_last_i && (nn == 4'd0);
    rec.slots[SlotFlush].valid = is_last_i && (nn != 4'd0);
    rec.slots[SlotFlush].data = flush_byte;
    rec.slots[SlotFlush].last = 1'b1;

    q_size_d = cfg_we_i ? cfg_data_i : q_size_q;
    acc_d = acc_q;
    held_d = held_q;
    hdr_d = hdr_q;
    if (accept_i) begin
      if (is_last_i) begin
        acc_d = '0;
        held_d = '0;
        hdr_d = 1'b0;
      end else begin
        acc_d = rem;
        held_d = nn[2:0];
        hdr_d = 1'b1;
      end
    end
  end

  assign rec_o = rec;
  assign rec_push_o = accept_i && (rec.slots[SlotHeader].valid || rec.slots[SlotData].valid ||
                                   rec.slots[SlotFlush].valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_size_q <= QSizeReset;
      acc_q <= '0;
      held_q <= '0;
      hdr_q <= 1'b0;
    end else begin
      q_size_q <= q_size_d;
      acc_q <= acc_d;
      held_q <= held_d;
      hdr_q <= hdr_d;
    end
  end

  // a frame's final item always pushes a record carrying the last flag
  a_last_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && is_last_i) |-> (rec_push_o &&
      (rec.slots[SlotData].last && rec.slots[SlotData].valid) !=
      rec.slots[SlotFlush].valid))
    else $error("last item without exactly one flagged byte");

endmodule

@@ rtl/mbp_queue.sv @@
// short record queue between front and back
module mbp_queue import mbp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output rec_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == FullCnt) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step with count");

endmodule

@@ rtl/mbp_back.sv @@
// back end: drains one record slot per beat onto the result side
module mbp_back import mbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  rec_t       q_rdata_i,
  output logic       q_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);

  rec_t                rec_q, rec_d;
  logic [NumSlots-1:0] live;
  logic [NumSlots-1:0] remain;
  logic [SlotW-1:0]    sel;
  logic                take;

  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      live[i] = rec_q.slots[i].valid;
    end
    sel = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (live[i]) begin
        sel = SlotW'(i);
      end
    end
    take = pop_i && (live != '0);
    remain = live;
    if (take) begin
      remain[sel] = 1'b0;
    end
    q_pop_o = (remain == '0) && !q_empty_i;
    rec_d = rec_q;
    if (q_pop_o) begin
      rec_d = q_rdata_i;
    end else if (take) begin
      rec_d.slots[sel].valid = 1'b0;
    end
  end

  assign empty_o = (live == '0);
  assign out_byte_o = rec_q.slots[sel].data;
  assign last_byte_o = rec_q.slots[sel].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  // a record is taken from the queue only once the working one is drained
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (live == '0 || (take && $onehot(live))))
    else $error("record loaded over pending bytes");

endmodule

@@ rtl/msb_first_bit_packer.sv @@
// top level of the msb-first bit packer
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------
//  input    | push_i / full_o         | field_value_i, is_last_i
//  result   | empty_o / pop_i         | out_byte_o, last_byte_o
//  config   | cfg_valid_i / cfg_ready_o | cfg_data_i (q_size)
//
// one item accepted per cycle unless full_o; its record is queued, then drained
// one beat per cycle while popped; a frame edge can add a header and a flush beat
// full_o rises when the record queue (Depth entries) is filled
// no clearing pass after reset; the config port is always ready
module msb_first_bit_packer import mbp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] field_value_i,
  input  logic       is_last_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  logic accept;
  logic rec_push;
  rec_t rec;
  logic q_full;
  logic q_empty;
  logic q_pop;
  rec_t q_rdata;

  assign cfg_ready_o = 1'b1;
  assign full_o = q_full;
  assign accept = push_i && !q_full;

  mbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .field_value_i (field_value_i),
    .is_last_i     (is_last_i),
    .rec_push_o    (rec_push),
    .rec_o         (rec)
  );

  mbp_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  mbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_rdata_i   (q_rdata),
    .q_pop_o     (q_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

@@ dv/tb_top.sv @@
// testbench for the msb-first bit packer: random frames, idling on both sides, byte checks
module tb_top;
  import mbp_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } field_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] field_value = 8'd0;
  logic       is_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = 4'd0;

  field_beat_t pending_fields[$];
  byte_beat_t  expected_bytes[$];
  int          err_cnt = 0;
  bit          burst_mode = 1'b0;
  bit          pressure_done = 1'b0;
  int          send_gap = 0;
  int          recv_hold = 0;

  // packer model state
  logic [3:0] model_qsize = QSizeReset;
  logic [7:0] model_bits = 8'd0;
  logic [2:0] model_count = 3'd0;
  bit         model_hdr_sent = 1'b0;

  msb_first_bit_packer DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_o       (full),
    .field_value_i(field_value),
    .is_last_i    (is_last),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte),
    .last_byte_o  (last_byte),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic pack_field(input logic [7:0] value, input logic lst);
    logic [3:0]  w;
    logic [15:0] acc;
    logic [15:0] tmp;
    int          n;
    byte_beat_t  beat;
    if (model_qsize < QSizeMin) w = QSizeMin;
    else if (model_qsize > QSizeMax) w = QSizeMax;
    else w = model_qsize;
    if (!model_hdr_sent) begin
      beat.data = {4'd0, w};
      beat.last = 1'b0;
      expected_bytes.insert(expected_bytes.size(), beat);
      model_hdr_sent = 1'b1;
    end
    acc = ({8'd0, model_bits & 8'h7F} << w) | ({8'd0, value} & ((16'd1 << w) - 16'd1));
    n = model_count + w;
    if (n >= 8) begin
      n = n - 8;
      tmp = acc >> n;
      beat.data = tmp[7:0];
      beat.last = lst && (n == 0);
      expected_bytes.insert(expected_bytes.size(), beat);
      acc = acc & ((16'd1 << n) - 16'd1);
    end
    if (lst) begin
      if (n > 0) begin
        tmp = acc << (8 - n);
        beat.data = tmp[7:0];
        beat.last = 1'b1;
        expected_bytes.insert(expected_bytes.size(), beat);
      end
      model_bits = 8'd0;
      model_count = 3'd0;
      model_hdr_sent = 1'b0;
    end else begin
      model_bits = acc[7:0] & ByteMask;
      model_count = n[2:0];
    end
  endtask

  // input driver
  always @(posedge clk) begin : field_driver
    bit holding;
    holding = push && full;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) pending_fields.delete(0);
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_fields.size() > 0) begin
          push <= 1'b1;
          field_value <= pending_fields[0].value;
          is_last <= pending_fields[0].last;
          send_gap = pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result side pops, with one long hold-off in burst mode
  always @(posedge clk) begin : byte_receiver
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (burst_mode && !pressure_done) begin
      pressure_done = 1'b1;
      recv_hold = 100;
      pop <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      pop <= 1'b0;
    end else if (burst_mode || $urandom_range(0, 99) < 65) begin
      pop <= 1'b1;
    end else begin
      pop <= 1'b0;
      recv_hold = pick_gap();
    end
  end

  // monitor: check popped beat, then track config and accepted fields
  always @(posedge clk) begin : byte_monitor
    byte_beat_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual data %h last %b",
                   $time, out_byte, last_byte);
          err_cnt++;
        end else begin
          want = expected_bytes.pop_front();
          if (want.data !== out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
            err_cnt++;
          end
          if (want.last !== last_byte) begin
            $display("%0t: last_byte expected %b actual %b", $time, want.last, last_byte);
            err_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) model_qsize = cfg_data;
      if (push && !full) pack_field(field_value, is_last);
    end
  end

  task automatic write_qsize(input logic [3:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_field(input logic [7:0] v, input logic lst);
    field_beat_t f;
    f.value = v;
    f.last = lst;
    pending_fields.insert(pending_fields.size(), f);
  endtask

  task automatic wait_drained();
    int guard = 0;
    while ((pending_fields.size() != 0 || push || expected_bytes.size() != 0) && guard < 50000)
    begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic add_frames(input int count);
    int n = 0;
    int len;
    while (n < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len && n < count; i++) begin
        add_field(8'($urandom_range(0, 255)), i == len - 1);
        n++;
      end
    end
  endtask

  initial begin : stimulus
    logic [3:0] q;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width, two fields make two full bytes
    add_field(8'hFF, 1'b0);
    add_field(8'h00, 1'b1);
    wait_drained();
    // single-bit fields, flush with padding
    write_qsize(4'd1);
    add_field(8'hFF, 1'b0);
    add_field(8'h00, 1'b0);
    add_field(8'hFF, 1'b1);
    wait_drained();
    // width zero packs as one bit
    write_qsize(4'd0);
    add_field(8'hFF, 1'b0);
    add_field(8'hFE, 1'b1);
    wait_drained();
    // widths above eight pack as eight
    write_qsize(4'd15);
    add_field(8'hA5, 1'b0);
    add_field(8'h5A, 1'b1);
    wait_drained();
    // width changed in the middle of a frame
    write_qsize(4'd3);
    add_field(8'hFF, 1'b0);
    add_field(8'h00, 1'b0);
    add_field(8'hFF, 1'b0);
    wait_drained();
    write_qsize(4'd5);
    add_field(8'hFF, 1'b0);
    add_field(8'h1F, 1'b1);
    wait_drained();
    // last field ends exactly on a byte, data beat carries last
    write_qsize(4'd4);
    add_field(8'hC3, 1'b0);
    add_field(8'h3C, 1'b1);
    wait_drained();
    // one-field frames
    write_qsize(4'd7);
    add_field(8'h55, 1'b1);
    wait_drained();
    write_qsize(4'd9);
    add_field(8'hFF, 1'b1);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: q = 4'd1;
        1: q = 4'd8;
        2: q = 4'd0;
        3: q = 4'd15;
        default: q = 4'($urandom_range(0, 15));
      endcase
      burst_mode = (p == 5);
      write_qsize(q);
      add_frames(54);
      wait_drained();
    end
    burst_mode = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, expected_bytes.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mbp_pkg.sv
rtl/mbp_front.sv
rtl/mbp_queue.sv
rtl/mbp_back.sv
rtl/msb_first_bit_packer.sv
dv/tb_top.sv
